// ===== hw/rtl/bedu_pkg.sv =====
// Shared types, command codes and network helper functions for the bit extract/deposit unit.
`default_nettype none

package bedu_pkg;

   localparam int WORD_BITS   = 64;
   localparam int STAGE_COUNT = 6;
   localparam int PAIR_COUNT  = 32;
   localparam int BYTE_BITS   = 8;
   localparam int BYTE_COUNT  = 8;
   localparam int RANK_COUNT  = 3;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [PAIR_COUNT-1:0] ctl_word_type;
   typedef ctl_word_type [STAGE_COUNT-1:0] ctl_set_type;
   typedef logic [3:0] local_count_type;
   typedef logic [5:0] count_type;
   typedef local_count_type [WORD_BITS-1:0] local_set_type;
   typedef count_type [WORD_BITS-1:0] count_set_type;

   typedef enum logic [1:0] {
      CMD_EXTRACT = 2'd0,
      CMD_DEPOSIT = 2'd1,
      CMD_REVERSE = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic     valid;
      cmd_type  cmd;
      word_type data;
      word_type mask;
   } beat_type;

   // Johnson counter of width 2**stage, advanced count times from zero.
   function automatic ctl_word_type johnson_decode(input count_type count,
                                                   input int unsigned stage);
      count_type   span;
      count_type   wrap;
      logic [32:0] field;
      logic [32:0] code;
      span  = count_type'(1 << stage);
      wrap  = count & count_type'((2 << stage) - 1);
      field = (33'd1 << span) - 33'd1;
      if (wrap < span) begin
         code = (33'd1 << wrap) - 33'd1;
      end else begin
         code = field & ~((33'd1 << (wrap - span)) - 33'd1);
      end
      return ctl_word_type'(code);
   endfunction

   // One butterfly layer: control 1 passes the pair, 0 swaps it.
   function automatic word_type butterfly(input word_type value, input ctl_word_type ctl,
                                          input int unsigned stage);
      int unsigned pair_gap;
      logic [5:0]  lo;
      logic [5:0]  hi;
      word_type    swapped;
      pair_gap = 1 << stage;
      swapped  = value;
      for (int unsigned n = 0; n < PAIR_COUNT; n++) begin
         lo = 6'((n >> stage) * (2 * pair_gap) + (n & (pair_gap - 1)));
         hi = 6'(lo + pair_gap);
         if (!ctl[n]) begin
            swapped[lo] = value[hi];
            swapped[hi] = value[lo];
         end
      end
      return swapped;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bedu_prefix.sv =====
// Two pipeline ranks that build running mask popcounts: per-byte, then global.
`default_nettype none

module bedu_prefix (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  bedu_pkg::beat_type      in_beat,
   output bedu_pkg::beat_type      out_beat,
   output bedu_pkg::count_set_type out_count
);
   import bedu_pkg::*;

   beat_type        beat1_in;
   beat_type        beat1_ff;
   beat_type        beat2_ff;
   local_set_type   local_in;
   local_set_type   local_ff;
   count_set_type   count_in;
   count_set_type   count_ff;
   local_count_type run;
   logic [6:0]      base;

   always_comb begin
      beat1_in = in_beat;
      if (in_beat.cmd == CMD_EXTRACT) begin
         beat1_in.data = in_beat.data & in_beat.mask;
      end
      run = '0;
      for (int y = 0; y < BYTE_COUNT; y++) begin
         run = '0;
         for (int i = 0; i < BYTE_BITS; i++) begin
            run = run + local_count_type'(in_beat.mask[y * BYTE_BITS + i]);
            local_in[y * BYTE_BITS + i] = run;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat1_ff.valid <= 1'b0;
      end else if (advance) begin
         beat1_ff <= beat1_in;
         local_ff <= local_in;
      end
   end

   // byte offsets added to local counts; only the low six bits matter
   always_comb begin
      base = '0;
      for (int y = 0; y < BYTE_COUNT; y++) begin
         for (int i = 0; i < BYTE_BITS; i++) begin
            count_in[y * BYTE_BITS + i] =
               count_type'(base + 7'(local_ff[y * BYTE_BITS + i]));
         end
         base = base + 7'(local_ff[y * BYTE_BITS + BYTE_BITS - 1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat2_ff.valid <= 1'b0;
      end else if (advance) begin
         beat2_ff <= beat1_ff;
         count_ff <= count_in;
      end
   end

   assign out_beat  = beat2_ff;
   assign out_count = count_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bedu_control.sv =====
// Pipeline rank that decodes prefix counts into butterfly swap controls.
`default_nettype none

module bedu_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  bedu_pkg::beat_type      in_beat,
   input  bedu_pkg::count_set_type in_count,
   output bedu_pkg::beat_type      out_beat,
   output bedu_pkg::ctl_set_type   out_ctl
);
   import bedu_pkg::*;

   wire ctl_set_type ctl_dec;
   ctl_set_type      ctl_in;
   ctl_set_type      ctl_ff;
   beat_type         beat_ff;

   for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_stage
      localparam int SPAN = 1 << s;
      for (genvar g = 0; g < PAIR_COUNT / SPAN; g++) begin : g_group
         ctl_word_type code;
         assign code = johnson_decode(in_count[2 * g * SPAN + SPAN - 1], s);
         assign ctl_dec[s][g * SPAN +: SPAN] = code[SPAN-1:0];
      end
   end

   // reverse: a set mask bit swaps every pair of that layer
   always_comb begin
      for (int s = 0; s < STAGE_COUNT; s++) begin
         if (in_beat.cmd == CMD_REVERSE) begin
            ctl_in[s] = in_beat.mask[s] ? '0 : '1;
         end else begin
            ctl_in[s] = ctl_dec[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= in_beat;
         ctl_ff  <= ctl_in;
      end
   end

   assign out_beat = beat_ff;
   assign out_ctl  = ctl_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bedu_network.sv =====
// Three-rank butterfly network, two layers per rank, direction set by command.
`default_nettype none

module bedu_network (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  bedu_pkg::beat_type    in_beat,
   input  bedu_pkg::ctl_set_type in_ctl,
   output bedu_pkg::beat_type    out_beat
);
   import bedu_pkg::*;

   wire beat_type    beat_at [RANK_COUNT+1];
   wire ctl_set_type ctl_at  [RANK_COUNT];

   assign beat_at[0] = in_beat;
   assign ctl_at[0]  = in_ctl;

   for (genvar p = 0; p < RANK_COUNT; p++) begin : g_rank
      localparam int FWD0 = 2 * p;
      localparam int FWD1 = 2 * p + 1;
      localparam int BWD0 = STAGE_COUNT - 1 - 2 * p;
      localparam int BWD1 = STAGE_COUNT - 2 - 2 * p;

      beat_type beat_in;
      beat_type beat_ff;

      // deposit walks the layers from the top down
      always_comb begin
         beat_in = beat_at[p];
         if (beat_at[p].cmd == CMD_DEPOSIT) begin
            beat_in.data = butterfly(butterfly(beat_at[p].data, ctl_at[p][BWD0], BWD0),
                                     ctl_at[p][BWD1], BWD1);
         end else begin
            beat_in.data = butterfly(butterfly(beat_at[p].data, ctl_at[p][FWD0], FWD0),
                                     ctl_at[p][FWD1], FWD1);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            beat_ff.valid <= 1'b0;
         end else if (advance) begin
            beat_ff <= beat_in;
         end
      end

      assign beat_at[p+1] = beat_ff;

      if (p < RANK_COUNT - 1) begin : g_ctl
         ctl_set_type ctl_ff;
         always_ff @(posedge clock) begin
            if (advance) begin
               ctl_ff <= ctl_at[p];
            end
         end
         assign ctl_at[p+1] = ctl_ff;
      end
   end

   assign out_beat = beat_at[RANK_COUNT];

endmodule

`default_nettype wire

// ===== hw/rtl/bit_extract_deposit_unit.sv =====
// Top level: input conditioning, pipeline, result fixup and output register.
// Seven register stages: the prefix ranks, the control rank, the network ranks and the output register.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits under stall.
// The running mask popcount is split into a per-byte rank and a global rank.
// Reset clears every stage valid bit; payload registers are not reset.
`default_nettype none

module bit_extract_deposit_unit #(
   parameter int DATA_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_data_word,
   input  logic [63:0] req_bit_mask,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_word
);
   import bedu_pkg::*;

   localparam logic [WORD_BITS:0] WIDE_ONE   = 1;
   localparam word_type           WIDTH_MASK =
      word_type'((WIDE_ONE << DATA_WIDTH) - WIDE_ONE);
   localparam logic [STAGE_COUNT-1:0] REV_ALLOW = {
      DATA_WIDTH > 32, DATA_WIDTH > 16, DATA_WIDTH > 8,
      DATA_WIDTH > 4,  DATA_WIDTH > 2,  DATA_WIDTH > 1
   };

   logic          advance;
   beat_type      in_beat;
   beat_type      pre_beat;
   count_set_type pre_count;
   beat_type      ctl_beat;
   ctl_set_type   ctl_set;
   beat_type      net_beat;
   word_type      result_in;
   word_type      rsp_result_ff;
   logic          rsp_valid_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      in_beat.valid = req_valid;
      in_beat.cmd   = cmd_type'(req_command);
      in_beat.data  = req_data_word & WIDTH_MASK;
      in_beat.mask  = req_bit_mask & WIDTH_MASK;
      if (in_beat.cmd == CMD_REVERSE) begin
         in_beat.mask[STAGE_COUNT-1:0] = in_beat.mask[STAGE_COUNT-1:0] & REV_ALLOW;
      end
   end

   bedu_prefix u_prefix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_beat   (in_beat),
      .out_beat  (pre_beat),
      .out_count (pre_count)
   );

   bedu_control u_control (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_beat  (pre_beat),
      .in_count (pre_count),
      .out_beat (ctl_beat),
      .out_ctl  (ctl_set)
   );

   bedu_network u_network (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_beat  (ctl_beat),
      .in_ctl   (ctl_set),
      .out_beat (net_beat)
   );

   always_comb begin
      case (net_beat.cmd)
         CMD_EXTRACT: result_in = net_beat.data;
         CMD_DEPOSIT: result_in = net_beat.data & net_beat.mask;
         CMD_REVERSE: result_in = net_beat.data;
         default:     result_in = '0;
      endcase
      result_in = result_in & WIDTH_MASK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff  <= net_beat.valid;
         rsp_result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_result_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_word & ~WIDTH_MASK) == '0)
      else $error("result bits above operand width");

   a_extract_count: assert property (@(posedge clock) disable iff (reset)
      (net_beat.valid && net_beat.cmd == CMD_EXTRACT) |->
         $countones(net_beat.data) <= $countones(net_beat.mask))
      else $error("extract network created bits");

endmodule

`default_nettype wire

// ===== tb/tb_bit_extract_deposit_unit.sv =====
// Self-checking testbench for bit_extract_deposit_unit: predicted extract/deposit/reverse words.
`default_nettype none

module tb_bit_extract_deposit_unit;
   import bedu_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 383;
   localparam int SETTLE      = 20;
   localparam logic [5:0][63:0] GROUP_LO = {
      64'h00000000FFFFFFFF, 64'h0000FFFF0000FFFF, 64'h00FF00FF00FF00FF,
      64'h0F0F0F0F0F0F0F0F, 64'h3333333333333333, 64'h5555555555555555
   };

   typedef struct {
      cmd_type     cmd;
      logic [63:0] data;
      logic [63:0] mask;
   } operation_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_EXTRACT;
   logic [63:0] req_data_word = '0;
   logic [63:0] req_bit_mask = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_word;

   operation_type pending_ops[$];
   logic [63:0]   expected_words[$];
   int            send_gap_pct = 0;
   int            recv_stall_pct = 0;
   bit            hold_armed = 1'b0;
   bit            hold_done = 1'b0;
   int            hold_left = 0;
   int            idle_cycles = 0;
   int            errors = 0;
   int            words_checked = 0;
   int            cmd_seen[4] = '{0, 0, 0, 0};

   bit_extract_deposit_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_data_word   (req_data_word),
      .req_bit_mask    (req_bit_mask),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_word (rsp_result_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Johnson counter of width w stepped n times from zero.
   function automatic logic [31:0] johnson_state(int unsigned w, int unsigned n);
      logic [31:0] v;
      logic [31:0] top;
      v   = '0;
      top = 32'd1 << (w - 1);
      for (int unsigned c = 0; c < n; c++) begin
         if ((v & top) != 0) v = (v ^ top) << 1;
         else v = (v << 1) | 32'd1;
      end
      return v;
   endfunction

   function automatic logic [5:0][31:0] network_controls(logic [63:0] mask);
      int unsigned      rank[64];
      int unsigned      run;
      int unsigned      k;
      int unsigned      pos;
      logic [5:0][31:0] ctl;
      run = 0;
      for (int b = 0; b < 64; b++) begin
         run += mask[b];
         rank[b] = run;
      end
      for (int s = 0; s < 6; s++) begin
         k      = 1 << s;
         ctl[s] = '0;
         for (int unsigned g = 0; g < 32 / k; g++) begin
            pos = (2 * g * k + k - 1) & 63;
            ctl[s] |= johnson_state(k, rank[pos]) << (g * k);
         end
      end
      return ctl;
   endfunction

   // Control bit set passes the pair, clear swaps it.
   function automatic logic [63:0] route_stage(logic [63:0] v, logic [31:0] ctl, int unsigned s);
      logic [63:0] r;
      int unsigned d;
      int unsigned n;
      int unsigned a;
      r = v;
      d = 1 << s;
      n = 0;
      for (int unsigned blk = 0; blk < (32 >> s); blk++) begin
         for (int unsigned off = 0; off < d; off++) begin
            a = blk * 2 * d + off;
            if (!ctl[n]) begin
               r[a]     = v[a + d];
               r[a + d] = v[a];
            end
            n++;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] predict_word(operation_type op);
      logic [5:0][31:0] ctl;
      logic [63:0]      v;
      ctl = network_controls(op.mask);
      v   = op.data;
      case (op.cmd)
         CMD_EXTRACT: begin
            v &= op.mask;
            for (int s = 0; s < 6; s++) v = route_stage(v, ctl[s], s);
         end
         CMD_DEPOSIT: begin
            for (int s = 5; s >= 0; s--) v = route_stage(v, ctl[s], s);
            v &= op.mask;
         end
         CMD_REVERSE: begin
            for (int s = 0; s < 6; s++) begin
               if (op.mask[s]) begin
                  v = ((v & GROUP_LO[s]) << (1 << s)) |
                      ((v & ~GROUP_LO[s]) >> (1 << s));
               end
            end
         end
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_mask();
      int unsigned lo;
      int unsigned len;
      lo  = $urandom_range(63);
      len = $urandom_range(1, 64);
      case ($urandom_range(7))
         0: return rand_word() & rand_word() & rand_word();
         1: return rand_word() | rand_word();
         2: return '0;
         3: return '1;
         4: return ((len == 64) ? '1 : ((64'd1 << len) - 64'd1)) << lo;
         5: return 64'd1 << lo;
         default: return rand_word();
      endcase
   endfunction

   task automatic add_op(cmd_type cmd, logic [63:0] data, logic [63:0] mask);
      operation_type op;
      op.cmd  = cmd;
      op.data = data;
      op.mask = mask;
      pending_ops.push_back(op);
   endtask

   task automatic add_random_op();
      int unsigned pick;
      cmd_type     cmd;
      pick = $urandom_range(15);
      if (pick < 6) cmd = CMD_EXTRACT;
      else if (pick < 12) cmd = CMD_DEPOSIT;
      else if (pick < 15) cmd = CMD_REVERSE;
      else cmd = CMD_UNUSED;
      add_op(cmd, rand_word(), rand_mask());
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || expected_words.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin : drive
      operation_type done_op;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            done_op = pending_ops.pop_front();
            expected_words.push_back(predict_word(done_op));
            cmd_seen[done_op.cmd]++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid     <= 1'b1;
               req_command   <= pending_ops[0].cmd;
               req_data_word <= pending_ops[0].data;
               req_bit_mask  <= pending_ops[0].mask;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      logic [63:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("rsp_result_word: expected none, actual %h", rsp_result_word);
            errors++;
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (rsp_result_word !== want) begin
               $error("rsp_result_word: expected %h, actual %h", want, rsp_result_word);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("bit_extract_deposit_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_op(CMD_EXTRACT, '1, '1);
      add_op(CMD_EXTRACT, '1, '0);
      add_op(CMD_EXTRACT, '0, '1);
      add_op(CMD_EXTRACT, rand_word(), 64'h8000000000000001);
      add_op(CMD_EXTRACT, rand_word(), 64'hAAAAAAAAAAAAAAAA);
      add_op(CMD_EXTRACT, rand_word(), 64'h5555555555555555);
      add_op(CMD_EXTRACT, '1, 64'hFFFFFFFF00000000);
      add_op(CMD_DEPOSIT, '1, '1);
      add_op(CMD_DEPOSIT, '1, '0);
      add_op(CMD_DEPOSIT, '1, 64'h8000000000000000);
      add_op(CMD_DEPOSIT, rand_word(), 64'hAAAAAAAAAAAAAAAA);
      add_op(CMD_DEPOSIT, 64'h00000000FFFFFFFF, 64'hF0F0F0F0F0F0F0F0);
      add_op(CMD_DEPOSIT, '1, 64'h0000000000000001);
      for (int s = 0; s < 6; s++) add_op(CMD_REVERSE, rand_word(), 64'd1 << s);
      add_op(CMD_REVERSE, rand_word(), 64'h000000000000003F);
      // upper mask bits only: reverse leaves the word alone
      add_op(CMD_REVERSE, rand_word(), 64'hFFFFFFFFFFFFFFC0);
      add_op(CMD_UNUSED, '1, '1);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         @(negedge clock);
         case (p)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 56; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 56; end
            default: begin send_gap_pct = 20; recv_stall_pct = 20; end
         endcase
         repeat (PHASE_ITEMS) add_random_op();
         // long output hold-off while input keeps offering beats
         if (p == 0) hold_armed = 1'b1;
         wait_drained();
      end

      repeat (SETTLE) @(negedge clock);
      $display("Covered %0d extract, %0d deposit, %0d reverse and %0d unused-code beats;",
               cmd_seen[CMD_EXTRACT], cmd_seen[CMD_DEPOSIT], cmd_seen[CMD_REVERSE],
               cmd_seen[CMD_UNUSED]);
      $display("%0d result beats checked under gaps, stalls and a long output hold.",
               words_checked);
      if (errors == 0) begin
         $display("bit_extract_deposit_unit: match");
      end else begin
         $display("bit_extract_deposit_unit: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
